// File: rtl/core/wpls_pkg.sv
// shared types, codes and constants of the winch pull level selector
package wpls_pkg;

  // up steps are held off until more than this many ms have passed since the last change
  localparam logic [31:0] UpHoldoffMs = 32'd1000;

  // floor(x / 100) for x below 2^14 as (x * RecipMul) >> RecipShift
  localparam int unsigned ProdW      = 14;
  localparam int unsigned RecipShift = 20;
  localparam logic [ProdW-1:0] RecipMul = 14'd10486;
  localparam logic [7:0] PullSatMax = 8'd127;

  // button event codes
  typedef enum logic [2:0] {
    MODE_TICK        = 3'd0,
    MODE_UP          = 3'd1,
    MODE_DOWN        = 3'd2,
    MODE_DOWN_LONG   = 3'd3,
    MODE_UP_LONG     = 3'd4,
    MODE_DOWN_DOUBLE = 3'd5,
    MODE_DOWN_REL    = 3'd6,
    MODE_UP_REL      = 3'd7
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MAX_PULL     = 3'd0,
    REG_HARD_BRAKE   = 3'd1,
    REG_SOFT_BRAKE   = 3'd2,
    REG_DEFAULT_PULL = 3'd3,
    REG_PRE_PCT      = 3'd4,
    REG_TAKEOFF_PCT  = 3'd5,
    REG_FULL_PCT     = 3'd6,
    REG_STRONG_PCT   = 3'd7
  } reg_idx_e;

  // pull levels
  localparam logic signed [3:0] LVL_HARD    = -4'sd2;
  localparam logic signed [3:0] LVL_SOFT    = -4'sd1;
  localparam logic signed [3:0] LVL_NEUTRAL = 4'sd0;
  localparam logic signed [3:0] LVL_DEFAULT = 4'sd1;
  localparam logic signed [3:0] LVL_PRE     = 4'sd2;
  localparam logic signed [3:0] LVL_TAKEOFF = 4'sd3;
  localparam logic signed [3:0] LVL_FULL    = 4'sd4;
  localparam logic signed [3:0] LVL_MAX     = 4'sd5;
  localparam logic signed [3:0] LVL_CUT     = -4'sd7;

  // long-press flags
  localparam logic [1:0] FLAG_DOWN_LONG = 2'b01;
  localparam logic [1:0] FLAG_UP_LONG   = 2'b10;
  localparam logic [1:0] FLAGS_BOTH     = 2'b11;

  typedef struct packed {
    logic [6:0]        max_pull;
    logic signed [7:0] hard_brake_pull;
    logic signed [7:0] soft_brake_pull;
    logic [6:0]        default_pull;
    logic [6:0]        pre_pct;
    logic [6:0]        takeoff_pct;
    logic [6:0]        full_pct;
    logic [6:0]        strong_pct;
  } cfg_t;

  typedef struct packed {
    logic signed [3:0] level;
    logic signed [3:0] reported_level;
    logic              level_changed;
    logic              cut_request;
  } lvl_res_t;

  typedef struct packed {
    lvl_res_t         res;
    logic [ProdW-1:0] product;
  } mid_t;

  typedef struct packed {
    lvl_res_t          res;
    logic signed [7:0] target_pull;
  } out_t;

endpackage

// File: rtl/core/wpls_if.sv
// item channel interfaces of the winch pull level selector

interface wpls_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] time_ms;

  modport source (output valid, mode, time_ms, input ready);
  modport sink (input valid, mode, time_ms, output ready);
endinterface

interface wpls_out_if;
  logic              valid;
  logic              ready;
  logic signed [3:0] level;
  logic signed [3:0] reported_level;
  logic signed [7:0] target_pull;
  logic              level_changed;
  logic              cut_request;

  modport source (output valid, level, reported_level, target_pull, level_changed,
                  cut_request, input ready);
  modport sink (input valid, level, reported_level, target_pull, level_changed,
                cut_request, output ready);
endinterface

// File: rtl/core/wpls_level_ctrl.sv
// pull level state and button event decoding
module wpls_level_ctrl import wpls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  mode_e       mode_i,
  input  logic [31:0] time_ms_i,
  output lvl_res_t    res_o
);

  logic signed [3:0] lvl_q, lvl_d;
  logic [31:0]       last_q, last_d;
  logic [1:0]        flags_q, flags_d;
  logic [31:0]       elapsed;
  logic              changed;
  logic              cut;

  // next level, change time and flags for the current event
  always_comb begin
    lvl_d   = lvl_q;
    last_d  = last_q;
    flags_d = flags_q;
    changed = 1'b0;
    elapsed = time_ms_i - last_q;
    case (mode_i)
      MODE_UP: begin
        if (elapsed > UpHoldoffMs && lvl_q < LVL_MAX) begin
          lvl_d   = (lvl_q == LVL_SOFT) ? LVL_DEFAULT : lvl_q + 4'sd1;
          last_d  = time_ms_i;
          changed = 1'b1;
        end
      end
      MODE_DOWN: begin
        if (lvl_q > LVL_DEFAULT) begin
          lvl_d   = LVL_DEFAULT;
          last_d  = time_ms_i;
          changed = 1'b1;
        end else if (lvl_q == LVL_SOFT || lvl_q == LVL_NEUTRAL) begin
          lvl_d   = lvl_q - 4'sd1;
          last_d  = time_ms_i;
          changed = 1'b1;
        end
      end
      MODE_DOWN_LONG: begin
        lvl_d   = LVL_SOFT;
        last_d  = time_ms_i;
        changed = 1'b1;
        flags_d = flags_q | FLAG_DOWN_LONG;
      end
      MODE_UP_LONG: begin
        flags_d = flags_q | FLAG_UP_LONG;
      end
      MODE_DOWN_DOUBLE: begin
        if (lvl_q <= LVL_SOFT) begin
          lvl_d   = LVL_NEUTRAL;
          last_d  = time_ms_i;
          changed = 1'b1;
        end
      end
      MODE_DOWN_REL: begin
        flags_d = flags_q & ~FLAG_DOWN_LONG;
      end
      MODE_UP_REL: begin
        flags_d = flags_q & ~FLAG_UP_LONG;
      end
      default: begin
      end
    endcase
    cut = (flags_d == FLAGS_BOTH);
  end

  always_comb begin
    res_o.level          = lvl_d;
    res_o.reported_level = cut ? LVL_CUT : lvl_d;
    res_o.level_changed  = changed;
    res_o.cut_request    = cut;
  end

  // state update once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q   <= LVL_SOFT;
      last_q  <= '0;
      flags_q <= '0;
    end else if (step_i) begin
      lvl_q   <= lvl_d;
      last_q  <= last_d;
      flags_q <= flags_d;
    end
  end

`ifndef SYNTH
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q >= LVL_HARD && lvl_q <= LVL_MAX)
    else $error("pull level out of range");

  a_down_long_soft: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_i == MODE_DOWN_LONG |=> lvl_q == LVL_SOFT)
    else $error("down long-press did not force soft brake");

  a_up_skips_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_i == MODE_UP && changed |=> lvl_q != LVL_NEUTRAL)
    else $error("up step landed on neutral");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_i == MODE_DOWN_REL |=> flags_q[0] == 1'b0)
    else $error("down release left the long-press flag set");
`endif

endmodule

// File: rtl/core/wpls_pull_scale.sv
// divide by 100, target pull selection and result register
module wpls_pull_scale import wpls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  mid_valid_i,
  input  mid_t  mid_i,
  input  cfg_t  cfg_i,
  input  logic  out_ready_i,
  output logic  mid_ready_o,
  output logic  out_valid_o,
  output out_t  out_o
);

  localparam int unsigned ScaledW = 2 * ProdW;

  logic [ScaledW-1:0] scaled;
  logic [7:0]         quot;
  logic signed [7:0]  pct_pull;
  logic signed [7:0]  target;
  logic               out_vld_q;
  out_t               out_q;
  logic               load;

  // quotient by reciprocal multiply, saturated to the signed range
  always_comb begin
    scaled   = ScaledW'(mid_i.product) * ScaledW'(RecipMul);
    quot     = scaled[RecipShift +: 8];
    pct_pull = (quot > PullSatMax) ? signed'(PullSatMax) : signed'(quot);
  end

  // pull for the level
  always_comb begin
    case (mid_i.res.level)
      LVL_HARD:    target = cfg_i.hard_brake_pull;
      LVL_SOFT:    target = cfg_i.soft_brake_pull;
      LVL_NEUTRAL: target = 8'sd0;
      LVL_DEFAULT: target = signed'({1'b0, cfg_i.default_pull});
      LVL_PRE, LVL_TAKEOFF, LVL_FULL, LVL_MAX: target = pct_pull;
      default:     target = cfg_i.soft_brake_pull;
    endcase
  end

  assign mid_ready_o = !out_vld_q || out_ready_i;
  assign load        = mid_valid_i && mid_ready_o;

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (mid_ready_o) begin
      out_vld_q <= mid_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.res         <= mid_i.res;
      out_q.target_pull <= target;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

// File: rtl/core/winch_pull_level_selector.sv
// top level of the winch pull level selector: input, product and result stages
// Stages: three register stages, for the input item, the product and the result.
// Throughput: one item per cycle while the result receiver does not stall; the level
//   state updates as an item leaves the input register, and the percent product and
//   its divide by 100 each get a stage of their own.
// Reset: level -1, change time 0, long-press flags clear, registers at defaults.
module winch_pull_level_selector import wpls_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  wpls_in_if.sink       in_i,
  wpls_out_if.source    out_o
);

  cfg_t        cfg_q;
  logic        in_vld_q;
  logic [2:0]  in_mode_q;
  logic [31:0] in_time_q;
  logic        mid_vld_q;
  mid_t        mid_q;
  mid_t        mid_d;
  lvl_res_t    lvl_res;
  logic        mid_ready;
  logic        adv_mid;
  logic        in_acc;
  logic [6:0]  pct;
  out_t        res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_pull        <= 7'd85;
      cfg_q.hard_brake_pull <= -8'sd20;
      cfg_q.soft_brake_pull <= -8'sd7;
      cfg_q.default_pull    <= 7'd7;
      cfg_q.pre_pct         <= 7'd18;
      cfg_q.takeoff_pct     <= 7'd55;
      cfg_q.full_pct        <= 7'd80;
      cfg_q.strong_pct      <= 7'd100;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MAX_PULL:     cfg_q.max_pull        <= cfg_data_i[6:0];
        REG_HARD_BRAKE:   cfg_q.hard_brake_pull <= signed'(cfg_data_i);
        REG_SOFT_BRAKE:   cfg_q.soft_brake_pull <= signed'(cfg_data_i);
        REG_DEFAULT_PULL: cfg_q.default_pull    <= cfg_data_i[6:0];
        REG_PRE_PCT:      cfg_q.pre_pct         <= cfg_data_i[6:0];
        REG_TAKEOFF_PCT:  cfg_q.takeoff_pct     <= cfg_data_i[6:0];
        REG_FULL_PCT:     cfg_q.full_pct        <= cfg_data_i[6:0];
        REG_STRONG_PCT:   cfg_q.strong_pct      <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // stage handshakes
  assign adv_mid    = in_vld_q && (!mid_vld_q || mid_ready);
  assign in_i.ready = !in_vld_q || adv_mid;
  assign in_acc     = in_i.valid && in_i.ready;

  // input item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_mode_q <= in_i.mode;
      in_time_q <= in_i.time_ms;
    end
  end

  // level state machine
  wpls_level_ctrl u_level_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv_mid),
    .mode_i    (mode_e'(in_mode_q)),
    .time_ms_i (in_time_q),
    .res_o     (lvl_res)
  );

  // percent for the new level and its product with max pull
  always_comb begin
    case (lvl_res.level)
      LVL_PRE:     pct = cfg_q.pre_pct;
      LVL_TAKEOFF: pct = cfg_q.takeoff_pct;
      LVL_FULL:    pct = cfg_q.full_pct;
      LVL_MAX:     pct = cfg_q.strong_pct;
      default:     pct = 7'd0;
    endcase
    mid_d.res     = lvl_res;
    mid_d.product = ProdW'(cfg_q.max_pull) * ProdW'(pct);
  end

  // product stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
    end else if (adv_mid) begin
      mid_vld_q <= 1'b1;
    end else if (mid_ready) begin
      mid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_mid) begin
      mid_q <= mid_d;
    end
  end

  // divide and result stage
  wpls_pull_scale u_pull_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_vld_q),
    .mid_i       (mid_q),
    .cfg_i       (cfg_q),
    .out_ready_i (out_o.ready),
    .mid_ready_o (mid_ready),
    .out_valid_o (out_o.valid),
    .out_o       (res)
  );

  assign out_o.level          = res.res.level;
  assign out_o.reported_level = res.res.reported_level;
  assign out_o.target_pull    = res.target_pull;
  assign out_o.level_changed  = res.res.level_changed;
  assign out_o.cut_request    = res.res.cut_request;

endmodule

// File: dv/winch_pull_level_selector_test.sv
// self-checking testbench of the winch pull level selector with its own level predictor
module winch_pull_level_selector_test;
  import wpls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit     = 500000;
  localparam int          DirN           = 25;
  localparam int          PhaseN         = 8;
  localparam int          PhaseItems     = 100;
  localparam int          LongHoldAt     = 250;
  localparam int          LongHoldCycles = 300;

  typedef struct packed {
    logic signed [3:0] level;
    logic signed [3:0] reported;
    logic signed [7:0] pull;
    logic              changed;
    logic              cut;
  } pull_result_t;

  typedef struct {
    mode_e        mode;
    logic [31:0]  t;
    bit           typed;
    pull_result_t res;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  wpls_in_if  ev_if ();
  wpls_out_if res_if ();

  winch_pull_level_selector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (ev_if),
    .out_o      (res_if)
  );

  // predictor state and register copies, at reset values
  logic signed [3:0] cur_level      = LVL_SOFT;
  logic [31:0]       last_change_ms = '0;
  logic [1:0]        press_flags    = '0;
  logic [6:0]        cur_max_pull   = 7'd85;
  logic signed [7:0] cur_hard_pull  = -8'sd20;
  logic signed [7:0] cur_soft_pull  = -8'sd7;
  logic [6:0]        cur_default    = 7'd7;
  logic [6:0]        cur_pre_pct    = 7'd18;
  logic [6:0]        cur_takeoff_pct = 7'd55;
  logic [6:0]        cur_full_pct   = 7'd80;
  logic [6:0]        cur_strong_pct = 7'd100;

  pull_result_t pull_results_q [$];
  int           failures      = 0;
  int           results_seen  = 0;
  bit           steady_phase  = 1'b0;
  bit           long_hold_done = 1'b0;
  int unsigned  cycle_count   = 0;
  logic [31:0]  now_ms        = '0;
  dir_row_t     dir_rows [DirN];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // pull for a percent level, saturated at the top of the signed range
  function automatic logic signed [7:0] percent_pull(logic [6:0] pct);
    logic [13:0] prod;
    logic [13:0] quot;
    prod = {7'd0, cur_max_pull} * {7'd0, pct};
    quot = prod / 14'd100;
    return (quot > 14'd127) ? 8'sd127 : $signed(quot[7:0]);
  endfunction

  // level state update for one event item, returns the expected result
  function automatic pull_result_t step_pull_level(mode_e m, logic [31:0] t);
    pull_result_t r;
    logic [31:0]  elapsed;
    logic         cut;
    r.changed = 1'b0;
    elapsed = t - last_change_ms;
    case (m)
      MODE_UP: begin
        if (elapsed > UpHoldoffMs && cur_level < LVL_MAX) begin
          cur_level = (cur_level == LVL_SOFT) ? LVL_DEFAULT : cur_level + 4'sd1;
          last_change_ms = t;
          r.changed = 1'b1;
        end
      end
      MODE_DOWN: begin
        if (cur_level > LVL_DEFAULT) begin
          cur_level = LVL_DEFAULT;
          last_change_ms = t;
          r.changed = 1'b1;
        end else if (cur_level > LVL_HARD && cur_level < LVL_DEFAULT) begin
          cur_level = cur_level - 4'sd1;
          last_change_ms = t;
          r.changed = 1'b1;
        end
      end
      MODE_DOWN_LONG: begin
        cur_level = LVL_SOFT;
        last_change_ms = t;
        r.changed = 1'b1;
        press_flags = press_flags | FLAG_DOWN_LONG;
      end
      MODE_UP_LONG: press_flags = press_flags | FLAG_UP_LONG;
      MODE_DOWN_DOUBLE: begin
        if (cur_level <= LVL_SOFT) begin
          cur_level = LVL_NEUTRAL;
          last_change_ms = t;
          r.changed = 1'b1;
        end
      end
      MODE_DOWN_REL: press_flags = press_flags & ~FLAG_DOWN_LONG;
      MODE_UP_REL: press_flags = press_flags & ~FLAG_UP_LONG;
      MODE_TICK: ;
      default: ;
    endcase
    cut = (press_flags == FLAGS_BOTH);
    r.level = cur_level;
    r.reported = cut ? LVL_CUT : cur_level;
    r.cut = cut;
    case (cur_level)
      LVL_HARD:    r.pull = cur_hard_pull;
      LVL_SOFT:    r.pull = cur_soft_pull;
      LVL_NEUTRAL: r.pull = 8'sd0;
      LVL_DEFAULT: r.pull = $signed({1'b0, cur_default});
      LVL_PRE:     r.pull = percent_pull(cur_pre_pct);
      LVL_TAKEOFF: r.pull = percent_pull(cur_takeoff_pct);
      LVL_FULL:    r.pull = percent_pull(cur_full_pct);
      LVL_MAX:     r.pull = percent_pull(cur_strong_pct);
      default:     r.pull = cur_soft_pull;
    endcase
    return r;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input int expd, input int act);
    if (expd != act) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expd, act);
      failures++;
    end
  endtask

  // offer one event item, predict it once accepted, then idle a while outside the steady phase
  task automatic send_event(input mode_e m, input logic [31:0] t, input bit typed,
                            input pull_result_t typed_res);
    pull_result_t pr;
    int gap;
    ev_if.valid   <= 1'b1;
    ev_if.mode    <= m;
    ev_if.time_ms <= t;
    do @(posedge clk_i); while (!ev_if.ready);
    pr = step_pull_level(m, t);
    pull_results_q.push_back(typed ? typed_res : pr);
    gap = steady_phase ? 0 : idle_len();
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every expected item has come back
  task automatic drain_results();
    ev_if.valid <= 1'b0;
    while (pull_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write all eight registers back to back, only while idle
  task automatic write_config(input logic [7:0] vals [8]);
    reg_idx_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_e'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      case (idx)
        REG_MAX_PULL:     cur_max_pull    = vals[i][6:0];
        REG_HARD_BRAKE:   cur_hard_pull   = $signed(vals[i]);
        REG_SOFT_BRAKE:   cur_soft_pull   = $signed(vals[i]);
        REG_DEFAULT_PULL: cur_default     = vals[i][6:0];
        REG_PRE_PCT:      cur_pre_pct     = vals[i][6:0];
        REG_TAKEOFF_PCT:  cur_takeoff_pct = vals[i][6:0];
        REG_FULL_PCT:     cur_full_pct    = vals[i][6:0];
        REG_STRONG_PCT:   cur_strong_pct  = vals[i][6:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // random event items, mostly timed so that up presses get past the hold-off
  task automatic run_random_phase(input int n_items);
    int    sent;
    int    r;
    mode_e m;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // climb toward the strongest level
        for (int k = 0; k < 7; k++) begin
          now_ms = now_ms + $urandom_range(1001, 1800);
          send_event(MODE_UP, now_ms, 1'b0, '0);
        end
        sent += 7;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55)      now_ms = now_ms + $urandom_range(1001, 4000);
        else if (r < 75) now_ms = now_ms + $urandom_range(0, 1000);
        else if (r < 85) now_ms = last_change_ms + $urandom_range(1000, 1001);
        else if (r < 95) now_ms = now_ms + $urandom_range(0, 20);
        else             now_ms = $urandom();
        r = $urandom_range(0, 99);
        if (r < 35)      m = MODE_UP;
        else if (r < 50) m = MODE_DOWN;
        else if (r < 57) m = MODE_DOWN_LONG;
        else if (r < 64) m = MODE_UP_LONG;
        else if (r < 74) m = MODE_DOWN_DOUBLE;
        else if (r < 82) m = MODE_DOWN_REL;
        else if (r < 90) m = MODE_UP_REL;
        else             m = MODE_TICK;
        send_event(m, now_ms, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // result checking against the oldest expectation
  always @(posedge clk_i) begin : result_check
    pull_result_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pull_results_q.size() == 0) begin
        $display("%0t: result item with no expectation: level %0d", $time, res_if.level);
        failures++;
      end else begin
        exp_r = pull_results_q.pop_front();
        check_field("level", exp_r.level, res_if.level);
        check_field("reported_level", exp_r.reported, res_if.reported_level);
        check_field("target_pull", exp_r.pull, res_if.target_pull);
        check_field("level_changed", exp_r.changed, res_if.level_changed);
        check_field("cut_request", exp_r.cut, res_if.cut_request);
      end
    end
  end

  // receiver ready with random stalls and one long hold-off
  initial begin : result_ready
    int stall_left;
    int hold;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && results_seen >= LongHoldAt) begin
        long_hold_done = 1'b1;
        res_if.ready <= 1'b0;
        for (hold = 0; hold < LongHoldCycles; hold++) @(posedge clk_i);
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (steady_phase) begin
        res_if.ready <= 1'b1;
      end else begin
        stall_left = idle_len();
        res_if.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // main sequence: reset, directed rows, then random phases over several settings
  initial begin : main_seq
    logic [7:0] vals [8];
    ev_if.valid   <= 1'b0;
    ev_if.mode    <= MODE_TICK;
    ev_if.time_ms <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_MAX_PULL;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;

    dir_rows = '{
      '{MODE_TICK,        32'd0,    1'b1, '{LVL_SOFT, LVL_SOFT, -8'sd7, 1'b0, 1'b0}},
      '{MODE_UP,          32'd500,  1'b1, '{LVL_SOFT, LVL_SOFT, -8'sd7, 1'b0, 1'b0}},
      '{MODE_UP,          32'd1000, 1'b0, '0},
      '{MODE_UP,          32'd1001, 1'b0, '0},
      '{MODE_UP,          32'd2002, 1'b0, '0},
      '{MODE_UP,          32'd3003, 1'b0, '0},
      '{MODE_UP,          32'd4004, 1'b0, '0},
      '{MODE_UP,          32'd5005, 1'b1, '{LVL_MAX, LVL_MAX, 8'sd85, 1'b1, 1'b0}},
      '{MODE_UP,          32'd6006, 1'b0, '0},
      '{MODE_DOWN,        32'd6100, 1'b0, '0},
      '{MODE_DOWN,        32'd6200, 1'b0, '0},
      '{MODE_DOWN_DOUBLE, 32'd6300, 1'b0, '0},
      '{MODE_DOWN_LONG,   32'd6400, 1'b0, '0},
      '{MODE_DOWN_LONG,   32'd6500, 1'b0, '0},
      '{MODE_UP_LONG,     32'd6600, 1'b1, '{LVL_SOFT, LVL_CUT, -8'sd7, 1'b0, 1'b1}},
      '{MODE_DOWN_REL,    32'd6800, 1'b0, '0},
      '{MODE_UP_REL,      32'd6900, 1'b0, '0},
      '{MODE_DOWN,        32'd7000, 1'b0, '0},
      '{MODE_DOWN,        32'd7100, 1'b0, '0},
      '{MODE_DOWN_DOUBLE, 32'd7200, 1'b0, '0},
      '{MODE_UP,          32'd7300, 1'b0, '0},
      '{MODE_DOWN,        32'd7400, 1'b0, '0},
      '{MODE_DOWN_LONG,   32'hFFFF_FE00, 1'b0, '0},
      '{MODE_UP,          32'h0000_0300, 1'b0, '0},
      '{MODE_UP_REL,      32'hFFFF_FFFF, 1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at reset settings
    for (int i = 0; i < DirN; i++)
      send_event(dir_rows[i].mode, dir_rows[i].t, dir_rows[i].typed, dir_rows[i].res);
    now_ms = 32'h0000_0300;

    for (int p = 0; p < PhaseN; p++) begin
      drain_results();
      case (p)
        1: vals = '{8'h7F, 8'h80, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        2: vals = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        3: vals = '{8'd20, 8'h81, 8'h81, 8'h00, 8'd100, 8'd100, 8'd100, 8'd100};
        4: vals = '{8'h7F, 8'h00, 8'h80, 8'h80, 8'd100, 8'd101, 8'd99, 8'd0};
        default: begin
          for (int k = 0; k < 8; k++) vals[k] = $urandom_range(0, 255);
        end
      endcase
      if (p > 0) write_config(vals);
      steady_phase = (p == 3);
      run_random_phase(PhaseItems);
    end
    steady_phase = 1'b0;

    drain_results();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
